// ===== design/gmv_pkg.sv =====
// gmv_pkg: shared widths, codes and bounds of the grouped mean/variance block.
// Used by the channel interfaces and by the front, back and top modules.
package gmv_pkg;

  localparam int SCORE_W      = 7;
  localparam int SCORE_SQ_W   = 14;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;

  localparam int GROUP_NUM_W  = 8;
  localparam int COUNT_W      = 13;
  localparam int MEAN_W       = 15;
  localparam int VAR_W        = 20;

  localparam int FRAC_BITS    = 8;
  localparam int QUO_BITS     = 20;

  localparam longint unsigned MEAN_Q8_MAX = 64'd25600;
  localparam longint unsigned VAR_Q8_MAX  = 64'd640000;

  typedef enum logic {
    KIND_GROUP = 1'b0,
    KIND_ALL   = 1'b1
  } result_kind_t;

endpackage

// ===== design/gmv_in_if.sv =====
// gmv_in_if: score sample channel (valid/ready plus one sample beat).
// Depends on gmv_pkg for field widths.
interface gmv_in_if;
  import gmv_pkg::*;

  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score_value;
  logic               group_end;
  logic               all_end;

  modport source (output valid, output score_value, output group_end, output all_end,
                  input ready);
  modport sink   (input valid, input score_value, input group_end, input all_end,
                  output ready);
endinterface

// ===== design/gmv_out_if.sv =====
// gmv_out_if: result channel (valid/ready plus one statistics beat).
// Depends on gmv_pkg for field widths.
interface gmv_out_if;
  import gmv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   result_kind;
  logic [GROUP_NUM_W-1:0] group_number;
  logic [COUNT_W-1:0]     sample_count;
  logic [MEAN_W-1:0]      mean_q8;
  logic [VAR_W-1:0]       variance_q8;
  logic                   last_result;

  modport source (output valid, output result_kind, output group_number,
                  output sample_count, output mean_q8, output variance_q8,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input group_number,
                  input sample_count, input mean_q8, input variance_q8,
                  input last_result, output ready);
endinterface

// ===== design/gmv_front.sv =====
// gmv_front: accepts sample beats, saturates scores and accumulates sum,
// sum of squares and count; pushes a closed-group job. Depends on gmv_pkg, gmv_in_if.
module gmv_front #(
  parameter int MAX_GROUP_SIZE = 4096,
  localparam int CW  = $clog2(MAX_GROUP_SIZE + 1),
  localparam int SW  = CW + gmv_pkg::SCORE_W,
  localparam int SQW = CW + gmv_pkg::SCORE_SQ_W,
  localparam int JW  = 1 + CW + SW + SQW
) (
  input  logic          clk,
  input  logic          rst_n,
  gmv_in_if.sink        in_chan,
  input  logic          q_full,
  output logic          q_push,
  output logic [JW-1:0] q_data
);
  import gmv_pkg::*;

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [SW-1:0]         sum_r, sum_nxt;
  logic [SQW-1:0]        sq_r, sq_nxt;
  logic [SCORE_W-1:0]    sc;
  logic [SCORE_SQ_W-1:0] sc_sq;
  logic                  take;
  logic                  accept;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;

  always_comb begin
    sc      = (in_chan.score_value > SCORE_MAX) ? SCORE_MAX : in_chan.score_value;
    sc_sq   = SCORE_SQ_W'(sc) * SCORE_SQ_W'(sc);
    take    = cnt_r < CW'(MAX_GROUP_SIZE);
    cnt_nxt = take ? cnt_r + CW'(1) : cnt_r;
    sum_nxt = take ? sum_r + SW'(sc) : sum_r;
    sq_nxt  = take ? sq_r + SQW'(sc_sq) : sq_r;
  end

  assign q_push = accept && in_chan.group_end;
  assign q_data = {in_chan.all_end, cnt_nxt, sum_nxt, sq_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
    end else if (accept) begin
      if (in_chan.group_end) begin
        cnt_r <= '0;
        sum_r <= '0;
        sq_r  <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
        sq_r  <= sq_nxt;
      end
    end
  end

endmodule

// ===== design/gmv_queue.sv =====
// gmv_queue: two-entry job queue between the front and the back.
// Standalone; payload width is a parameter.
module gmv_queue #(
  parameter int W = 59
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);

  logic [W-1:0] slots_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head_data  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== design/gmv_div.sv =====
// gmv_div: restoring divider, one quotient bit per cycle.
// Quotient must be known to fit in QB bits. Standalone.
module gmv_div #(
  parameter int DW = 27,
  parameter int VW = 13,
  parameter int QB = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [QB-1:0] quotient
);

  localparam int XW   = (DW > VW + QB) ? DW : VW + QB;
  localparam int CNTW = $clog2(QB + 1);

  logic [XW-1:0]   rem_r;
  logic [XW-1:0]   dsh_r;
  logic [QB-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic            ge;

  assign ge       = rem_r >= dsh_r;
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNTW'(1));
      if (start) begin
        rem_r  <= XW'(dividend);
        dsh_r  <= XW'(divisor) << (QB - 1);
        q_r    <= '0;
        cnt_r  <= CNTW'(QB);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        q_r   <= {q_r[QB-2:0], ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/gmv_back.sv =====
// gmv_back: per-group sequencer; shared multiplier, two dividers, running totals
// and the output register. Depends on gmv_pkg, gmv_div, gmv_out_if.
module gmv_back #(
  parameter int MAX_GROUP_SIZE = 4096,
  parameter int MAX_GROUPS     = 256,
  localparam int CW  = $clog2(MAX_GROUP_SIZE + 1),
  localparam int SW  = CW + gmv_pkg::SCORE_W,
  localparam int SQW = CW + gmv_pkg::SCORE_SQ_W,
  localparam int JW  = 1 + CW + SW + SQW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  logic [JW-1:0] job_data,
  output logic          job_pop,
  gmv_out_if.source     out_chan
);
  import gmv_pkg::*;

  localparam int GW  = $clog2(MAX_GROUPS + 1);
  localparam int PW  = CW + SQW;
  localparam int SSW = 2 * SW;
  localparam int NNW = 2 * CW;
  localparam int MA  = SW;
  localparam int MB  = SQW;
  localparam int TMW = $clog2(MAX_GROUPS * MEAN_Q8_MAX + 1);
  localparam int TVW = $clog2(MAX_GROUPS * VAR_Q8_MAX + 1);
  localparam int DMW = (SW + FRAC_BITS > TMW) ? SW + FRAC_BITS : TMW;
  localparam int VMW = (CW > GW) ? CW : GW;
  localparam int DVW = (PW + FRAC_BITS > TVW) ? PW + FRAC_BITS : TVW;
  localparam int VVW = (NNW > GW) ? NNW : GW;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_NSQ, S_MUL_SS, S_MUL_NN, S_DIV_GRP,
    S_WAIT_GRP, S_EMIT_GRP, S_WAIT_ALL, S_EMIT_ALL
  } state_t;

  state_t                 state_r;
  logic [CW-1:0]          n_r;
  logic [SW-1:0]          s_r;
  logic [SQW-1:0]         sq_r;
  logic                   aend_r;
  logic [PW-1:0]          nsq_r;
  logic [SSW-1:0]         ss_r;
  logic [NNW-1:0]         nn_r;
  logic [QUO_BITS-1:0]    mean_r;
  logic [QUO_BITS-1:0]    var_r;
  logic [GROUP_NUM_W-1:0] num_r;
  logic [TMW-1:0]         tot_m_r;
  logic [TVW-1:0]         tot_v_r;
  logic [GW-1:0]          gdone_r;

  logic                   out_valid_r;
  logic                   out_kind_r;
  logic [GROUP_NUM_W-1:0] out_num_r;
  logic [COUNT_W-1:0]     out_cnt_r;
  logic [MEAN_W-1:0]      out_mean_r;
  logic [VAR_W-1:0]       out_var_r;
  logic                   out_last_r;

  logic [MA-1:0]          ma;
  logic [MB-1:0]          mb;
  logic [MA+MB-1:0]       prod;
  logic [PW-1:0]          diff;
  logic                   slot_free;
  logic                   emit;
  logic                   div_start;
  logic                   div_all;
  logic [DMW-1:0]         dm_dividend;
  logic [VMW-1:0]         dm_divisor;
  logic [DVW-1:0]         dv_dividend;
  logic [VVW-1:0]         dv_divisor;
  logic                   dm_done;
  logic                   dv_done;
  logic [QUO_BITS-1:0]    qm;
  logic [QUO_BITS-1:0]    qv;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_kind  = out_kind_r;
  assign out_chan.group_number = out_num_r;
  assign out_chan.sample_count = out_cnt_r;
  assign out_chan.mean_q8      = out_mean_r;
  assign out_chan.variance_q8  = out_var_r;
  assign out_chan.last_result  = out_last_r;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign emit      = slot_free && ((state_r == S_EMIT_GRP) || (state_r == S_EMIT_ALL));
  assign job_pop   = (state_r == S_IDLE) && job_valid;

  always_comb begin
    case (state_r)
      S_MUL_SS: begin
        ma = s_r;
        mb = MB'(s_r);
      end
      S_MUL_NN: begin
        ma = MA'(n_r);
        mb = MB'(n_r);
      end
      default: begin
        ma = MA'(n_r);
        mb = sq_r;
      end
    endcase
  end

  assign prod = (MA+MB)'(ma) * (MA+MB)'(mb);
  assign diff = nsq_r - PW'(ss_r);

  assign div_all   = state_r == S_EMIT_GRP;
  assign div_start = (state_r == S_DIV_GRP) || (div_all && slot_free && aend_r);

  assign dm_dividend = div_all ? DMW'(tot_m_r) : DMW'({s_r, {FRAC_BITS{1'b0}}});
  assign dm_divisor  = div_all ? VMW'(gdone_r) : VMW'(n_r);
  assign dv_dividend = div_all ? DVW'(tot_v_r) : DVW'({diff, {FRAC_BITS{1'b0}}});
  assign dv_divisor  = div_all ? VVW'(gdone_r) : VVW'(nn_r);

  gmv_div #(.DW(DMW), .VW(VMW), .QB(QUO_BITS)) u_div_mean (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dm_dividend),
    .divisor  (dm_divisor),
    .done     (dm_done),
    .quotient (qm)
  );

  gmv_div #(.DW(DVW), .VW(VVW), .QB(QUO_BITS)) u_div_var (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .done     (dv_done),
    .quotient (qv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tot_m_r     <= '0;
      tot_v_r     <= '0;
      gdone_r     <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            {aend_r, n_r, s_r, sq_r} <= job_data;
            state_r <= S_MUL_NSQ;
          end
        end
        S_MUL_NSQ: begin
          nsq_r   <= PW'(prod);
          state_r <= S_MUL_SS;
        end
        S_MUL_SS: begin
          ss_r    <= SSW'(prod);
          state_r <= S_MUL_NN;
        end
        S_MUL_NN: begin
          nn_r    <= NNW'(prod);
          state_r <= S_DIV_GRP;
        end
        S_DIV_GRP: begin
          state_r <= S_WAIT_GRP;
        end
        S_WAIT_GRP: begin
          if (dm_done && dv_done) begin
            mean_r <= qm;
            var_r  <= qv;
            if (gdone_r < GW'(MAX_GROUPS)) begin
              num_r   <= GROUP_NUM_W'(gdone_r);
              gdone_r <= gdone_r + GW'(1);
              tot_m_r <= tot_m_r + TMW'(qm);
              tot_v_r <= tot_v_r + TVW'(qv);
            end else begin
              num_r <= GROUP_NUM_W'(MAX_GROUPS - 1);
            end
            state_r <= S_EMIT_GRP;
          end
        end
        S_EMIT_GRP: begin
          if (slot_free) begin
            out_kind_r  <= KIND_GROUP;
            out_num_r   <= num_r;
            out_cnt_r   <= COUNT_W'(n_r);
            out_mean_r  <= MEAN_W'(mean_r);
            out_var_r   <= VAR_W'(var_r);
            out_last_r  <= !aend_r;
            state_r     <= aend_r ? S_WAIT_ALL : S_IDLE;
          end
        end
        S_WAIT_ALL: begin
          if (dm_done && dv_done) begin
            mean_r  <= qm;
            var_r   <= qv;
            state_r <= S_EMIT_ALL;
          end
        end
        S_EMIT_ALL: begin
          if (slot_free) begin
            out_kind_r  <= KIND_ALL;
            out_num_r   <= GROUP_NUM_W'(gdone_r - GW'(1));
            out_cnt_r   <= COUNT_W'(gdone_r);
            out_mean_r  <= MEAN_W'(mean_r);
            out_var_r   <= VAR_W'(var_r);
            out_last_r  <= 1'b1;
            tot_m_r     <= '0;
            tot_v_r     <= '0;
            gdone_r     <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/grouped_mean_variance.sv =====
// grouped_mean_variance: top level; front accumulator, job queue and back sequencer.
// Depends on gmv_pkg, gmv_in_if, gmv_out_if, gmv_front, gmv_queue, gmv_back.
//
// Samples are accepted one beat per cycle while the queue is not full; sum, sum of
// squares and count build up in the front with no stall. A beat with group_end
// closes the group and queues it (two closed groups fit in the queue;
// in_chan.ready drops while it is full). For each closed group the back forms
// n*sumsq, sum^2 and n^2 in turn on the shared multiplier, then runs the
// bit-per-cycle dividers for the Q8 mean and variance, then loads the output
// register. A group with all_end runs the dividers again for the overall averages.
// Groups shorter than the back-end time fill the queue and stall the input.
// Results sit in an output register, so the back keeps going while the sink stalls
// until its next result is ready.
module grouped_mean_variance #(
  parameter int MAX_GROUP_SIZE = 4096,
  parameter int MAX_GROUPS     = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  gmv_in_if.sink    in_chan,
  gmv_out_if.source out_chan
);
  import gmv_pkg::*;

  localparam int CW  = $clog2(MAX_GROUP_SIZE + 1);
  localparam int JW  = 1 + CW + (CW + SCORE_W) + (CW + SCORE_SQ_W);

  logic          q_push;
  logic [JW-1:0] q_push_data;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [JW-1:0] q_head;

  gmv_front #(.MAX_GROUP_SIZE(MAX_GROUP_SIZE)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_push_data)
  );

  gmv_queue #(.W(JW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  gmv_back #(.MAX_GROUP_SIZE(MAX_GROUP_SIZE), .MAX_GROUPS(MAX_GROUPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_data  (q_head),
    .job_pop   (q_pop),
    .out_chan  (out_chan)
  );

endmodule

// ===== tb/tb_grouped_mean_variance.sv =====
`timescale 1ns / 1ps
// tb_grouped_mean_variance: self-checking bench for the grouped mean/variance block.
// Depends on gmv_pkg, gmv_in_if, gmv_out_if and grouped_mean_variance; directed rows
// give some group beats, a local model of the sums predicts the rest, checked in order.
module tb_grouped_mean_variance;
  import gmv_pkg::*;

  localparam int GROUP_SIZE_CAP = 4096;
  localparam int GROUP_SLOTS    = 256;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_BEATS   = 1200;
  localparam int MAX_REPORTS    = 60;

  typedef struct packed {
    result_kind_t           kind;
    logic [GROUP_NUM_W-1:0] num;
    logic [COUNT_W-1:0]     cnt;
    logic [MEAN_W-1:0]      mean;
    logic [VAR_W-1:0]       variance;
    logic                   last;
  } stat_beat_t;

  typedef struct {
    logic [SCORE_W-1:0] score;
    bit                 gend;
    bit                 aend;
    int                 reps;
    bit                 typed;
    stat_beat_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gmv_in_if  in_chan ();
  gmv_out_if out_chan ();

  grouped_mean_variance #(
    .MAX_GROUP_SIZE(GROUP_SIZE_CAP),
    .MAX_GROUPS(GROUP_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  always #4 clk = ~clk;

  longint unsigned grp_sum, grp_sq_sum, grp_cnt;
  longint unsigned closed_groups, mean_total, var_total;

  stat_beat_t pending_stats_q[$];
  stim_row_t  stim_rows[$];
  bit         beat_typed;
  stat_beat_t beat_want;
  int         src_idle_pct;
  int         sink_stall_pct;
  bit         hold_results;
  int         fail_count;
  int         cycle_count;
  int         beats_sent;
  int         group_beats;
  int         overall_beats;

  // fold one accepted sample into the group sums; queue the stats it closes
  task automatic accumulate_score(input logic [SCORE_W-1:0] raw, input bit gend,
                                  input bit aend, input bit typed, input stat_beat_t want);
    logic [SCORE_W-1:0] capped;
    longint unsigned score, n, s, mean, variance, num;
    stat_beat_t beat;
    capped = (raw > SCORE_MAX) ? SCORE_MAX : raw;
    score = 64'(capped);
    if (grp_cnt < 64'(GROUP_SIZE_CAP)) begin
      grp_sum += score;
      grp_sq_sum += score * score;
      grp_cnt += 1;
    end
    if (!gend) return;
    n = grp_cnt;
    s = grp_sum;
    mean = (s << FRAC_BITS) / n;
    variance = ((n * grp_sq_sum - s * s) << FRAC_BITS) / (n * n);
    if (closed_groups < 64'(GROUP_SLOTS)) begin
      num = closed_groups;
      closed_groups += 1;
      mean_total += mean;
      var_total += variance;
    end else begin
      num = 64'(GROUP_SLOTS - 1);
    end
    grp_sum = 0;
    grp_sq_sum = 0;
    grp_cnt = 0;
    beat.kind = KIND_GROUP;
    beat.num = num[GROUP_NUM_W-1:0];
    beat.cnt = n[COUNT_W-1:0];
    beat.mean = mean[MEAN_W-1:0];
    beat.variance = variance[VAR_W-1:0];
    beat.last = !aend;
    pending_stats_q.push_back(typed ? want : beat);
    if (!aend) return;
    num = closed_groups - 1;
    mean = mean_total / closed_groups;
    variance = var_total / closed_groups;
    beat.kind = KIND_ALL;
    beat.num = num[GROUP_NUM_W-1:0];
    beat.cnt = closed_groups[COUNT_W-1:0];
    beat.mean = mean[MEAN_W-1:0];
    beat.variance = variance[VAR_W-1:0];
    beat.last = 1'b1;
    pending_stats_q.push_back(beat);
    closed_groups = 0;
    mean_total = 0;
    var_total = 0;
  endtask

  always @(posedge clk) begin
    stat_beat_t got;
    stat_beat_t want;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      accumulate_score(in_chan.score_value, in_chan.group_end, in_chan.all_end,
                       beat_typed, beat_want);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.kind = result_kind_t'(out_chan.result_kind);
      got.num = out_chan.group_number;
      got.cnt = out_chan.sample_count;
      got.mean = out_chan.mean_q8;
      got.variance = out_chan.variance_q8;
      got.last = out_chan.last_result;
      if (got.kind == KIND_ALL) overall_beats++;
      else group_beats++;
      if (pending_stats_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result beat: kind %0d group %0d count %0d mean %0d var %0d last %0d",
                   $time, got.kind, got.num, got.cnt, got.mean, got.variance, got.last);
      end else begin
        want = pending_stats_q.pop_front();
        if (got != want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: result mismatch, expected kind %0d group %0d count %0d mean %0d var %0d last %0d",
                     $time, want.kind, want.num, want.cnt, want.mean, want.variance, want.last);
            $display("%0t:                    got kind %0d group %0d count %0d mean %0d var %0d last %0d",
                     $time, got.kind, got.num, got.cnt, got.mean, got.variance, got.last);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    out_chan.ready <= !hold_results && ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, pending_stats_q.size());
    $display("grouped_mean_variance: mismatch");
    $finish;
  end

  // starts and ends at a falling edge
  task automatic send_beat(input logic [SCORE_W-1:0] score, input bit gend, input bit aend,
                           input bit typed, input stat_beat_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.score_value = score;
    in_chan.group_end = gend;
    in_chan.all_end = aend;
    beat_typed = typed;
    beat_want = want;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_chan.valid = 1'b0;
    while (pending_stats_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic dir_row(input logic [SCORE_W-1:0] score, input bit gend, input bit aend,
                         input int reps, input bit typed = 1'b0, input int num = 0,
                         input int cnt = 0, input int mean = 0, input int variance = 0,
                         input bit last = 1'b0);
    stim_row_t row;
    row.score = score;
    row.gend = gend;
    row.aend = aend;
    row.reps = reps;
    row.typed = typed;
    row.want.kind = KIND_GROUP;
    row.want.num = GROUP_NUM_W'(num);
    row.want.cnt = COUNT_W'(cnt);
    row.want.mean = MEAN_W'(mean);
    row.want.variance = VAR_W'(variance);
    row.want.last = last;
    stim_rows.push_back(row);
  endtask

  task automatic send_random_group();
    int len;
    int pick;
    bit aend;
    logic [SCORE_W-1:0] score;
    pick = $urandom_range(99);
    if (pick < 80) len = $urandom_range(8, 1);
    else if (pick < 95) len = $urandom_range(40, 9);
    else len = $urandom_range(200, 41);
    aend = ($urandom_range(4) == 0);
    for (int i = 1; i <= len; i++) begin
      if ($urandom_range(9) == 0) score = SCORE_W'($urandom_range(127, 101));
      else score = SCORE_W'($urandom_range(100));
      // stray all_end on a mid-group beat must be ignored
      send_beat(score, i == len, (i == len) ? aend : ($urandom_range(9) == 0), 1'b0, '0);
    end
  endtask

  initial begin
    int target;
    in_chan.valid = 1'b0;
    in_chan.score_value = '0;
    in_chan.group_end = 1'b0;
    in_chan.all_end = 1'b0;
    out_chan.ready = 1'b0;
    beat_typed = 1'b0;
    beat_want = '0;
    hold_results = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    //      score gend aend reps typed num  cnt   mean   var    last
    dir_row(0,    1,   1,   1,   1,    0,   1,    0,     0,     0);
    dir_row(100,  1,   0,   1,   1,    0,   1,    25600, 0,     1);
    dir_row(127,  1,   0,   1,   1,    1,   1,    25600, 0,     1);  // saturates
    dir_row(0,    0,   0,   1);
    dir_row(100,  1,   0,   1,   1,    2,   2,    12800, 640000, 1);
    dir_row(55,   0,   1,   1);                                       // all_end alone
    dir_row(55,   1,   1,   1,   1,    3,   2,    14080, 0,     0);
    dir_row(100,  0,   0,   4096);                                    // fill to the cap
    dir_row(0,    1,   0,   1,   1,    0,   4096, 25600, 0,     1);  // dropped sample
    dir_row(7,    1,   0,   255);                                     // use up group slots
    dir_row(9,    1,   0,   1,   1,    255, 1,    2304,  0,     1);  // past the last slot
    dir_row(85,   0,   0,   1);
    dir_row(42,   1,   1,   1,   1,    255, 2,    16256, 118336, 0);

    foreach (stim_rows[r]) begin
      for (int k = 0; k < stim_rows[r].reps; k++)
        send_beat(stim_rows[r].score, stim_rows[r].gend, stim_rows[r].aend,
                  stim_rows[r].typed, stim_rows[r].want);
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          // long sink hold-off while samples keep coming
          fork
            begin
              @(posedge clk);
              hold_results = 1'b1;
              repeat (HOLD_CYCLES) @(posedge clk);
              hold_results = 1'b0;
            end
          join_none
        end
        1: begin
          src_idle_pct = 82;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 82;
        end
        default: begin
          src_idle_pct = 27;
          sink_stall_pct = 27;
        end
      endcase
      target = beats_sent + RANDOM_BEATS / 4;
      while (beats_sent < target) send_random_group();
      drain_results();
    end

    $display("Sent %0d sample beats; checked %0d group and %0d overall results,",
             beats_sent, group_beats, overall_beats);
    $display("including saturated scores, a capped group, slot overflow and stalls.");
    if (fail_count == 0) begin
      $display("grouped_mean_variance: match");
    end else begin
      $display("grouped_mean_variance: mismatch");
    end
    $finish;
  end

endmodule
